// ----- sv/wpre_pkg.sv -----
// ----------------------------------------------------------------------------
// wpre_pkg: shared types and constants of the widest-path route engine
// Holds sizes, action codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package wpre_pkg;

  localparam int MaxNodes  = 16;
  localparam int NodeBits  = 4;
  localparam int CountBits = 5;
  localparam int WidthBits = 16;
  localparam int CellBits  = 2 * NodeBits;

  localparam logic [CountBits-1:0] NodeCountReset = 5'd16;
  localparam logic [WidthBits-1:0] SelfWidthReset = 16'hFFFF;

  localparam logic [0:0] RegNodeCount = 1'd0;
  localparam logic [0:0] RegSelfWidth = 1'd1;

  typedef enum logic [2:0] {
    ACT_SET_EDGE  = 3'd0,
    ACT_SET_LINK  = 3'd1,
    ACT_NODE_DOWN = 3'd2,
    ACT_NODE_UP   = 3'd3,
    ACT_COMPUTE   = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE_AB,
    ST_WRITE_BA,
    ST_DOWN,
    ST_UP,
    ST_INIT,
    ST_SELECT,
    ST_SEL_DONE,
    ST_RELAX,
    ST_WALK_START,
    ST_WALK,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;  // zero one edge memory entry
    logic rd_sel_row;  // edge read row is the selected node, else the source
    logic load;        // capture the accepted beat
    logic wr_ab;       // write edge or link at (a,b)
    logic wr_ba;       // write edge or link at (b,a)
    logic down_step;   // clear links a<->i, i = counter
    logic up_step;     // activate row counter among alive nodes
    logic init_step;   // init entry counter from the source row
    logic sel_clear;   // start a selection scan
    logic sel_step;    // examine node counter for selection
    logic sel_commit;  // mark selected node visited
    logic relax_step;  // relax node counter from the selected node
    logic walk_start;  // start a predecessor walk for destination counter
    logic walk_step;   // one walk step
    logic emit;        // present the result for destination counter
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t            action;
    logic               a_ok;
    logic               b_ok;
    logic               walk_done;
    logic               clear_last;
    logic [CountBits-1:0] n;
  } stat_t;

endpackage
`default_nettype wire

// ----- sv/wpre_datapath.sv -----
// ----------------------------------------------------------------------------
// wpre_datapath: matrices, Dijkstra state and result register
// Executes one step per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
`default_nettype none
module wpre_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire wpre_pkg::cmd_t                      cmd,
  input  wire logic [wpre_pkg::NodeBits-1:0]       idx,
  input  wire logic [wpre_pkg::NodeBits-1:0]       rd_idx,
  output wpre_pkg::stat_t                          stat,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [wpre_pkg::WidthBits-1:0]      cfg_data,
  input  wire logic [2:0]                          in_action,
  input  wire logic [wpre_pkg::NodeBits-1:0]       in_a,
  input  wire logic [wpre_pkg::NodeBits-1:0]       in_b,
  input  wire logic [wpre_pkg::WidthBits-1:0]      in_bw,
  input  wire logic                                in_up,
  output logic [wpre_pkg::NodeBits-1:0]            res_dest,
  output logic [wpre_pkg::NodeBits-1:0]            res_hop,
  output logic                                     res_reach,
  output logic [wpre_pkg::WidthBits-1:0]           res_width,
  output logic                                     res_last
);

  localparam int N  = wpre_pkg::MaxNodes;
  localparam int NB = wpre_pkg::NodeBits;
  localparam int WB = wpre_pkg::WidthBits;
  localparam int CB = wpre_pkg::CountBits;

  logic [CB-1:0] node_count;
  logic [WB-1:0] self_width;
  logic [CB-1:0] n_eff;

  logic [2:0]    action;
  logic [NB-1:0] a_reg;
  logic [NB-1:0] b_reg;
  logic [WB-1:0] bw_reg;
  logic          up_reg;

  // Edge bandwidth lives in a memory; link and alive are flops.
  logic [WB-1:0] edge_mem [N*N];
  logic [N-1:0]  link [N];
  logic [N-1:0]  alive;

  logic [wpre_pkg::CellBits-1:0] clr_addr;

  logic [WB-1:0] best [N];
  logic [NB-1:0] pred [N];
  logic [N-1:0]  pvalid;
  logic [N-1:0]  visited;

  logic [WB-1:0] top;
  logic [NB-1:0] sel;
  logic [NB-1:0] walk_k;
  logic [CB-1:0] walk_steps;

  logic [NB-1:0] edge_row;
  logic [WB-1:0] edge_rd;
  logic [WB-1:0] sel_best;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= wpre_pkg::NodeCountReset;
      self_width <= wpre_pkg::SelfWidthReset;
    end else if (cfg_we) begin
      if (cfg_index == wpre_pkg::RegNodeCount) begin
        node_count <= cfg_data[CB-1:0];
      end else begin
        self_width <= cfg_data;
      end
    end
  end

  assign n_eff = (node_count > CB'(N)) ? CB'(N) : node_count;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= in_action;
      a_reg  <= in_a;
      b_reg  <= in_b;
      bw_reg <= in_bw;
      up_reg <= in_up;
    end
  end

  assign stat.action    = wpre_pkg::action_t'(action);
  assign stat.a_ok      = {1'b0, a_reg} < n_eff;
  assign stat.b_ok      = {1'b0, b_reg} < n_eff;
  assign stat.n         = n_eff;
  assign stat.walk_done = !pvalid[walk_k] || (pred[walk_k] == a_reg)
                          || (walk_steps >= n_eff);
  assign stat.clear_last = (clr_addr == '1);

  // Clearing pass after reset walks every edge memory entry once.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Edge memory: one write port, one registered read port. The controller
  // presents the next column ahead of its use; the row is the selected node
  // during relaxation and the source otherwise.
  always_comb begin
    edge_row = cmd.rd_sel_row ? sel : a_reg;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      edge_mem[clr_addr] <= '0;
    end else if (cmd.wr_ab && action == wpre_pkg::ACT_SET_EDGE) begin
      edge_mem[{a_reg, b_reg}] <= bw_reg;
    end else if (cmd.wr_ba) begin
      edge_mem[{b_reg, a_reg}] <= bw_reg;
    end
  end

  always_ff @(posedge clk) begin
    edge_rd <= edge_mem[{edge_row, rd_idx}];
  end

  assign sel_best = best[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        link[i] <= N'(1) << i;
      end
      alive <= '0;
    end else begin
      if (cmd.wr_ab && action == wpre_pkg::ACT_SET_LINK) begin
        link[a_reg][b_reg] <= up_reg;
        link[b_reg][a_reg] <= up_reg;
      end
      if (cmd.down_step) begin
        alive[a_reg]     <= 1'b0;
        link[a_reg][idx] <= 1'b0;
        link[idx][a_reg] <= 1'b0;
      end
      if (cmd.up_step) begin
        for (int j = 0; j < N; j++) begin
          if ((alive[idx] || idx == a_reg) && (alive[j] || NB'(j) == a_reg)
              && j < int'(n_eff)) begin
            link[idx][j] <= 1'b1;
          end
        end
        alive[a_reg] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      pvalid  <= '0;
    end else begin
      if (cmd.init_step) begin
        pvalid[idx]  <= 1'b0;
        pred[idx]    <= '0;
        visited[idx] <= (idx == a_reg);
        if (idx == a_reg) begin
          best[idx] <= self_width;
        end else if (link[a_reg][idx]) begin
          best[idx] <= edge_rd;
          if (edge_rd != '0) begin
            pred[idx]   <= a_reg;
            pvalid[idx] <= 1'b1;
          end
        end else begin
          best[idx] <= '0;
        end
      end
      if (cmd.sel_clear) begin
        top <= '0;
        sel <= a_reg;
      end
      if (cmd.sel_step) begin
        if (best[idx] > top && !visited[idx] && link[a_reg][idx]) begin
          top <= best[idx];
          sel <= idx;
        end
      end
      if (cmd.sel_commit) begin
        visited[sel] <= 1'b1;
      end
      if (cmd.relax_step) begin
        if (best[idx] < sel_best && best[idx] < edge_rd && !visited[idx]
            && link[sel][idx]) begin
          best[idx]   <= (sel_best > edge_rd) ? edge_rd : sel_best;
          pred[idx]   <= sel;
          pvalid[idx] <= 1'b1;
        end
      end
      if (cmd.walk_start) begin
        walk_k     <= idx;
        walk_steps <= '0;
      end
      if (cmd.walk_step) begin
        walk_k     <= pred[walk_k];
        walk_steps <= walk_steps + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_dest <= idx;
      res_last <= ({1'b0, idx} + 1'b1) == n_eff;
      if (idx == a_reg) begin
        res_hop   <= a_reg;
        res_reach <= 1'b1;
        res_width <= best[idx];
      end else if (best[idx] != '0) begin
        res_hop   <= walk_k;
        res_reach <= 1'b1;
        res_width <= best[idx];
      end else begin
        res_hop   <= '0;
        res_reach <= 1'b0;
        res_width <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/wpre_ctrl.sv -----
// ----------------------------------------------------------------------------
// wpre_ctrl: sequencer of the widest-path route engine
// Steps the datapath through updates, Dijkstra rounds, walks and result beats.
// ----------------------------------------------------------------------------
`default_nettype none
module wpre_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  input  wire wpre_pkg::stat_t               stat,
  output wpre_pkg::cmd_t                     cmd,
  output logic [wpre_pkg::NodeBits-1:0]      idx,
  output logic [wpre_pkg::NodeBits-1:0]      rd_idx
);

  localparam int NB = wpre_pkg::NodeBits;
  localparam int CB = wpre_pkg::CountBits;

  wpre_pkg::state_t state, state_next;
  logic [NB-1:0] idx_next;
  logic [CB-1:0] round, round_next;
  logic          ov_next;
  logic          last_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wpre_pkg::ST_CLEAR;
      idx       <= '0;
      round     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      round     <= round_next;
      out_valid <= ov_next;
    end
  end

  assign last_idx = ({1'b0, idx} + 1'b1) >= stat.n;

  // The edge memory read is addressed with the column of the next cycle.
  assign rd_idx = idx_next;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    round_next = round;
    ov_next    = out_valid && out_stall;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      wpre_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = wpre_pkg::ST_IDLE;
      end
      wpre_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = wpre_pkg::ST_WRITE_AB;
        end
      end
      wpre_pkg::ST_WRITE_AB: begin
        // Dispatch once the beat's fields are in the datapath.
        idx_next   = '0;
        state_next = wpre_pkg::ST_IDLE;
        if (stat.a_ok) begin
          case (stat.action)
            wpre_pkg::ACT_SET_EDGE, wpre_pkg::ACT_SET_LINK: begin
              if (stat.b_ok) begin
                cmd.wr_ab  = 1'b1;
                state_next = wpre_pkg::ST_WRITE_BA;
              end
            end
            wpre_pkg::ACT_NODE_DOWN: state_next = wpre_pkg::ST_DOWN;
            wpre_pkg::ACT_NODE_UP:   state_next = wpre_pkg::ST_UP;
            wpre_pkg::ACT_COMPUTE:   state_next = wpre_pkg::ST_INIT;
            default:                 state_next = wpre_pkg::ST_IDLE;
          endcase
        end
      end
      wpre_pkg::ST_WRITE_BA: begin
        cmd.wr_ba  = (stat.action == wpre_pkg::ACT_SET_EDGE);
        state_next = wpre_pkg::ST_IDLE;
      end
      wpre_pkg::ST_DOWN: begin
        cmd.down_step = 1'b1;
        idx_next      = idx + 1'b1;
        if (last_idx) state_next = wpre_pkg::ST_IDLE;
      end
      wpre_pkg::ST_UP: begin
        cmd.up_step = 1'b1;
        idx_next    = idx + 1'b1;
        if (last_idx) state_next = wpre_pkg::ST_IDLE;
      end
      wpre_pkg::ST_INIT: begin
        cmd.init_step = 1'b1;
        idx_next      = idx + 1'b1;
        round_next    = 5'd1;
        if (last_idx) begin
          idx_next   = '0;
          state_next = (round_next < stat.n) ? wpre_pkg::ST_SELECT
                                             : wpre_pkg::ST_WALK_START;
          cmd.sel_clear = 1'b1;
        end
      end
      wpre_pkg::ST_SELECT: begin
        cmd.sel_step = 1'b1;
        idx_next     = idx + 1'b1;
        if (last_idx) begin
          idx_next   = '0;
          state_next = wpre_pkg::ST_SEL_DONE;
        end
      end
      wpre_pkg::ST_SEL_DONE: begin
        cmd.sel_commit = 1'b1;
        cmd.rd_sel_row = 1'b1;
        state_next     = wpre_pkg::ST_RELAX;
      end
      wpre_pkg::ST_RELAX: begin
        cmd.relax_step = 1'b1;
        cmd.rd_sel_row = 1'b1;
        idx_next       = idx + 1'b1;
        if (last_idx) begin
          idx_next   = '0;
          round_next = round + 1'b1;
          cmd.sel_clear = 1'b1;
          state_next = (round_next < stat.n) ? wpre_pkg::ST_SELECT
                                             : wpre_pkg::ST_WALK_START;
        end
      end
      wpre_pkg::ST_WALK_START: begin
        cmd.walk_start = 1'b1;
        state_next     = wpre_pkg::ST_WALK;
      end
      wpre_pkg::ST_WALK: begin
        if (stat.walk_done) begin
          state_next = wpre_pkg::ST_EMIT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      wpre_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit = 1'b1;
          ov_next  = 1'b1;
          idx_next = idx + 1'b1;
          state_next = last_idx ? wpre_pkg::ST_IDLE : wpre_pkg::ST_WALK_START;
        end
      end
      default: state_next = wpre_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/widest_path_route_engine.sv -----
// ----------------------------------------------------------------------------
// widest_path_route_engine: max-bottleneck route computation engine
// Holds the graph and emits one route beat per destination on compute.
// ----------------------------------------------------------------------------
// An input beat carries one action. After reset the engine zeroes its edge
// memory and stalls its input meanwhile. The sequencer accepts a beat and
// dispatches it; edge and link writes then pass through the two write
// states, node down clears the links of node a one node at a time, node up
// sets one matrix row per node, and compute runs an init scan over the n
// nodes, then n-1 rounds of a selection scan, a commit and a relaxation
// scan, then per destination a walk start, up to n predecessor steps, a
// check and a result beat, plus any time a result waits on out_stall.
// Results leave through an output register, so a waiting result does
// not block the sequencer from finishing its walk.
// Actions naming a node at or above node_count produce nothing.
`default_nettype none
module widest_path_route_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  action,
  input  wire logic [3:0]  node_a,
  input  wire logic [3:0]  node_b,
  input  wire logic [15:0] bandwidth,
  input  wire logic        link_up,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       destination,
  output logic [3:0]       next_hop,
  output logic             reachable,
  output logic [15:0]      path_width,
  output logic             last
);

  wpre_pkg::cmd_t  cmd;
  wpre_pkg::stat_t stat;
  logic [wpre_pkg::NodeBits-1:0] idx;
  logic [wpre_pkg::NodeBits-1:0] rd_idx;

  wpre_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .stat(stat), .cmd(cmd),
    .idx(idx), .rd_idx(rd_idx)
  );

  wpre_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .idx(idx), .rd_idx(rd_idx), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index[0]), .cfg_data(cfg_data),
    .in_action(action), .in_a(node_a), .in_b(node_b), .in_bw(bandwidth),
    .in_up(link_up), .res_dest(destination), .res_hop(next_hop),
    .res_reach(reachable), .res_width(path_width), .res_last(last)
  );

endmodule
`default_nettype wire

// ----- sv/wpre_checker.sv -----
// ----------------------------------------------------------------------------
// wpre_checker: port-level checks of the widest-path route engine
// Watches the handshakes and the route beats on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module wpre_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  destination,
  input wire logic [3:0]  next_hop,
  input wire logic        reachable,
  input wire logic [15:0] path_width
);

  // A stalled result beat stays valid and keeps its destination.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(destination))
    else $error("result beat changed while stalled");

  // An unreachable entry carries zero width and hop zero.
  a_unreach: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reachable |-> path_width == 16'd0 && next_hop == 4'd0)
    else $error("unreachable entry has nonzero fields");

  // After accepting a beat the engine is busy the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

endmodule

bind widest_path_route_engine wpre_checker u_wpre_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .destination(destination),
  .next_hop(next_hop), .reachable(reachable), .path_width(path_width)
);
`default_nettype wire
